// ----- hdl/pcsm_pkg.sv -----
// ============================================================================
// pcsm_pkg
// Types and constants shared by the p-code stack machine files.
// ============================================================================
package pcsm_pkg;

    localparam int DATA_W   = 32;
    localparam int STACK_AW = 12;     // 4096 stack entries
    localparam int PC_W     = 11;     // 2048 code locations
    localparam int SAVE_AW  = 7;      // 128 save entries

    // Instruction codes
    localparam logic [4:0] OP_LIT = 5'd0;
    localparam logic [4:0] OP_OPR = 5'd1;
    localparam logic [4:0] OP_LOD = 5'd2;
    localparam logic [4:0] OP_STO = 5'd3;
    localparam logic [4:0] OP_CAL = 5'd4;
    localparam logic [4:0] OP_INT = 5'd5;
    localparam logic [4:0] OP_JMP = 5'd6;
    localparam logic [4:0] OP_JPC = 5'd7;
    localparam logic [4:0] OP_END = 5'd8;
    localparam logic [4:0] OP_STR = 5'd9;
    localparam logic [4:0] OP_GIV = 5'd10;
    localparam logic [4:0] OP_LDR = 5'd11;
    localparam logic [4:0] OP_LDA = 5'd12;
    localparam logic [4:0] OP_STA = 5'd13;
    localparam logic [4:0] OP_SAV = 5'd14;
    localparam logic [4:0] OP_GET = 5'd15;
    localparam logic [4:0] OP_REA = 5'd16;
    localparam logic [4:0] OP_WRI = 5'd17;

    // Operator codes carried in the operand of opr
    localparam logic signed [31:0] OPR_RET1 = -32'sd1;
    localparam logic signed [31:0] OPR_RET0 = 32'sd0;
    localparam logic signed [31:0] OPR_NEG  = 32'sd1;
    localparam logic signed [31:0] OPR_ADD  = 32'sd2;
    localparam logic signed [31:0] OPR_SUB  = 32'sd3;
    localparam logic signed [31:0] OPR_MUL  = 32'sd4;
    localparam logic signed [31:0] OPR_DIV  = 32'sd5;
    localparam logic signed [31:0] OPR_REM  = 32'sd6;
    localparam logic signed [31:0] OPR_EQ   = 32'sd8;
    localparam logic signed [31:0] OPR_NE   = 32'sd9;
    localparam logic signed [31:0] OPR_LT   = 32'sd10;
    localparam logic signed [31:0] OPR_GE   = 32'sd11;
    localparam logic signed [31:0] OPR_GT   = 32'sd12;
    localparam logic signed [31:0] OPR_LE   = 32'sd13;

    // Str sub-codes
    localparam logic signed [31:0] STR_POPIX = 32'sd1;
    localparam logic signed [31:0] STR_LINK  = 32'sd2;

    typedef struct packed {
        logic [4:0]         op;
        logic [3:0]         level;
        logic signed [31:0] operand;
        logic signed [31:0] read_value;
    } t_in_item;

    typedef struct packed {
        logic [10:0]        next_pc;
        logic signed [31:0] write_value;
        logic               write_valid;
        logic               halted;
        logic               fault;
    } t_out_item;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_TOP,
        ST_WALK_RD,
        ST_WALK_WT,
        ST_EXEC,
        ST_RD2,
        ST_RD3,
        ST_CAL2,
        ST_CAL3,
        ST_DIV,
        ST_WB
    } t_state;

endpackage

// ----- hdl/pcsm_div.sv -----
// ============================================================================
// pcsm_div
// Signed restoring divider, one quotient bit per cycle, truncating toward 0.
// ============================================================================
module pcsm_div (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic signed [31:0]       i_dividend,
    input  logic signed [31:0]       i_divisor,
    output logic                     o_done,
    output logic signed [31:0]       o_quot,
    output logic signed [31:0]       o_rem
);

    logic        r_busy;
    logic        r_done;
    logic [4:0]  r_cnt;
    logic [31:0] r_q;
    logic [31:0] r_r;
    logic [31:0] r_d;
    logic        r_qneg;
    logic        r_rneg;

    logic [32:0] w_sh;
    logic [32:0] w_diff;
    logic        w_ge;

    always_comb begin
        w_sh   = {r_r, r_q[31]};
        w_diff = w_sh - {1'b0, r_d};
        w_ge   = ~w_diff[32];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: load magnitudes, then shift and subtract
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q    <= i_dividend[31] ? 32'(-i_dividend) : i_dividend;
            r_d    <= i_divisor[31] ? 32'(-i_divisor) : i_divisor;
            r_r    <= '0;
            r_qneg <= i_dividend[31] ^ i_divisor[31];
            r_rneg <= i_dividend[31];
        end else if (r_busy) begin
            r_q <= {r_q[30:0], w_ge};
            r_r <= w_ge ? w_diff[31:0] : w_sh[31:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_qneg ? -$signed(r_q) : $signed(r_q);
    assign o_rem  = r_rneg ? -$signed(r_r) : $signed(r_r);

endmodule

// ----- hdl/pcode_stack_machine.sv -----
// ============================================================================
// pcode_stack_machine
// PL/0-style p-code interpreter core: one instruction per input transaction.
// ============================================================================
//
//  channel | signals                              | direction
//  --------+--------------------------------------+----------
//  input   | i_in_valid, o_in_ready, i_in_data    | in
//  output  | o_out_valid, i_out_ready, o_out_data | out
//
//  Steps: simple instructions pass accept, top read and execute; each
//  static-level hop adds a stack read and its wait state, loads add RD2,
//  binary operators add RD2 and WB, cal adds CAL2 and CAL3, returns add
//  RD2 and RD3, and div/rem also wait for the bit-serial divider. Stack
//  memory accesses set the pace.
//  Reset: a clearing pass writes zero to all 4096 stack entries, one per
//  cycle; no transaction is accepted until it ends.
//  Stalls: the result sits in an output register; a finishing instruction
//  holds while that register is still full and not being taken.
// ============================================================================
module pcode_stack_machine (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  pcsm_pkg::t_in_item    i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output pcsm_pkg::t_out_item   o_out_data
);

    localparam int AW = pcsm_pkg::STACK_AW;
    localparam int DW = pcsm_pkg::DATA_W;
    localparam int PW = pcsm_pkg::PC_W;
    localparam int SW = pcsm_pkg::SAVE_AW;

    // Stack and save memories
    logic [DW-1:0] r_stack [0:(1<<AW)-1];
    logic [DW-1:0] r_save  [0:(1<<SW)-1];
    logic [DW-1:0] r_rdata;
    logic [DW-1:0] r_sdata;

    // Architectural state
    pcsm_pkg::t_state r_state, n_state;
    logic [AW-1:0] r_top,  n_top;
    logic [AW-1:0] r_base, n_base;
    logic [PW-1:0] r_pc,   n_pc;
    logic signed [DW-1:0] r_ix, n_ix;
    logic [SW-1:0] r_sp,   n_sp;
    logic [AW-1:0] r_clr;

    // Per-instruction working registers
    pcsm_pkg::t_in_item r_in;
    logic signed [DW-1:0] r_tv,   n_tv;
    logic signed [DW-1:0] r_sv,   n_sv;
    logic signed [DW-1:0] r_walk, n_walk;
    logic [3:0]    r_cnt,  n_cnt;
    logic [PW-1:0] r_pn,   n_pn;
    logic          r_flt,  n_flt;
    logic          r_rdok, n_rdok;
    logic signed [DW-1:0] r_res, n_res;

    // Output register
    logic                r_ovalid;
    pcsm_pkg::t_out_item r_odata, n_odata;

    // Memory access controls
    logic          w_we;
    logic [AW-1:0] w_waddr;
    logic [DW-1:0] w_wdata;
    logic [AW-1:0] w_raddr;
    logic          w_swe;
    logic [SW-1:0] w_swaddr;

    // Decode and control
    logic w_is_ret, w_is_bin, w_is_div, w_walks;
    logic w_fin, w_fin_ok, w_hold, w_accept;
    logic signed [DW-1:0] w_wv;
    logic w_wvld;
    logic signed [DW+1:0] w_ea;
    logic w_ea_ok;
    logic signed [DW-1:0] w_x;
    logic signed [2*DW-1:0] w_prod;
    logic [AW:0] w_t2, w_t3, w_t4, w_b1, w_b2;

    logic w_div_start, w_div_done;
    logic signed [DW-1:0] w_quot, w_rem;

    pcsm_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_x),
        .i_divisor  (r_tv),
        .o_done     (w_div_done),
        .o_quot     (w_quot),
        .o_rem      (w_rem)
    );

    assign o_in_ready  = (r_state == pcsm_pkg::ST_IDLE);
    assign w_accept    = i_in_valid && o_in_ready;
    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_odata;
    assign w_fin_ok    = !r_ovalid || i_out_ready;
    assign w_hold      = w_fin && !w_fin_ok;
    assign w_x         = $signed(r_rdata);

    // Decode
    always_comb begin
        w_is_ret = (r_in.operand == pcsm_pkg::OPR_RET1) || (r_in.operand == pcsm_pkg::OPR_RET0);
        w_is_bin = ((r_in.operand >= pcsm_pkg::OPR_ADD) && (r_in.operand <= pcsm_pkg::OPR_REM))
                || ((r_in.operand >= pcsm_pkg::OPR_EQ) && (r_in.operand <= pcsm_pkg::OPR_LE));
        w_is_div = (r_in.operand == pcsm_pkg::OPR_DIV) || (r_in.operand == pcsm_pkg::OPR_REM);
        w_walks  = (r_in.op == pcsm_pkg::OP_LOD) || (r_in.op == pcsm_pkg::OP_STO)
                || (r_in.op == pcsm_pkg::OP_CAL) || (r_in.op == pcsm_pkg::OP_LDA)
                || (r_in.op == pcsm_pkg::OP_STA);
        w_t2 = {1'b0, r_top} + (AW+1)'(2);
        w_t3 = {1'b0, r_top} + (AW+1)'(3);
        w_t4 = {1'b0, r_top} + (AW+1)'(4);
        w_b1 = {1'b0, r_base} + (AW+1)'(1);
        w_b2 = {1'b0, r_base} + (AW+1)'(2);
    end

    // Effective address for the frame and indexed accesses
    always_comb begin
        case (r_in.op)
            pcsm_pkg::OP_GIV:
                w_ea = $signed({2'b00, {(DW-AW){1'b0}}, r_top})
                     + (DW+2)'(r_in.operand) + (DW+2)'(1);
            pcsm_pkg::OP_LDA, pcsm_pkg::OP_STA:
                w_ea = (DW+2)'(r_walk) + (DW+2)'(r_ix) + (DW+2)'(2);
            default:
                w_ea = (DW+2)'(r_walk) + (DW+2)'(r_in.operand) + (DW+2)'(2);
        endcase
        w_ea_ok = (w_ea[DW+1:AW] == '0);
    end

    // Which states complete an instruction
    always_comb begin
        case (r_state)
            pcsm_pkg::ST_EXEC:
                w_fin = !((r_in.op == pcsm_pkg::OP_OPR) && (w_is_ret || w_is_bin))
                     && (r_in.op != pcsm_pkg::OP_LOD) && (r_in.op != pcsm_pkg::OP_LDA)
                     && (r_in.op != pcsm_pkg::OP_CAL);
            pcsm_pkg::ST_RD2:
                w_fin = (r_in.op != pcsm_pkg::OP_OPR) || (w_is_bin && w_is_div && (r_tv == '0));
            pcsm_pkg::ST_RD3, pcsm_pkg::ST_CAL3, pcsm_pkg::ST_WB:
                w_fin = 1'b1;
            default:
                w_fin = 1'b0;
        endcase
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            pcsm_pkg::ST_CLEAR:
                if (r_clr == '1) n_state = pcsm_pkg::ST_IDLE;
            pcsm_pkg::ST_IDLE:
                if (i_in_valid) n_state = pcsm_pkg::ST_TOP;
            pcsm_pkg::ST_TOP:
                n_state = (w_walks && (r_in.level != '0)) ? pcsm_pkg::ST_WALK_RD
                                                           : pcsm_pkg::ST_EXEC;
            pcsm_pkg::ST_WALK_RD:
                if (r_walk[DW-1:AW] == '0) n_state = pcsm_pkg::ST_WALK_WT;
                else if (r_cnt == 4'd1) n_state = pcsm_pkg::ST_EXEC;
            pcsm_pkg::ST_WALK_WT:
                n_state = (r_cnt == 4'd1) ? pcsm_pkg::ST_EXEC : pcsm_pkg::ST_WALK_RD;
            pcsm_pkg::ST_EXEC:
                if (r_in.op == pcsm_pkg::OP_CAL) n_state = pcsm_pkg::ST_CAL2;
                else if (!w_fin) n_state = pcsm_pkg::ST_RD2;
                else if (w_fin_ok) n_state = pcsm_pkg::ST_IDLE;
            pcsm_pkg::ST_RD2:
                if (w_fin) begin
                    if (w_fin_ok) n_state = pcsm_pkg::ST_IDLE;
                end else if (w_is_ret) n_state = pcsm_pkg::ST_RD3;
                else if (w_is_div) n_state = pcsm_pkg::ST_DIV;
                else n_state = pcsm_pkg::ST_WB;
            pcsm_pkg::ST_CAL2:
                n_state = pcsm_pkg::ST_CAL3;
            pcsm_pkg::ST_DIV:
                if (w_div_done) n_state = pcsm_pkg::ST_WB;
            pcsm_pkg::ST_RD3, pcsm_pkg::ST_CAL3, pcsm_pkg::ST_WB:
                if (w_fin_ok) n_state = pcsm_pkg::ST_IDLE;
            default:
                n_state = pcsm_pkg::ST_IDLE;
        endcase
    end

    // Datapath and memory controls
    always_comb begin
        n_top   = r_top;
        n_base  = r_base;
        n_pc    = r_pc;
        n_ix    = r_ix;
        n_sp    = r_sp;
        n_tv    = r_tv;
        n_sv    = r_sv;
        n_walk  = r_walk;
        n_cnt   = r_cnt;
        n_pn    = r_pn;
        n_flt   = r_flt;
        n_rdok  = r_rdok;
        n_res   = r_res;
        w_we    = 1'b0;
        w_waddr = r_top;
        w_wdata = r_tv;
        w_raddr = r_top;
        w_swe   = 1'b0;
        w_swaddr = r_sp;
        w_wv    = '0;
        w_wvld  = 1'b0;
        w_div_start = 1'b0;
        w_prod  = r_tv * w_x;

        case (r_state)
            pcsm_pkg::ST_CLEAR: begin
                w_we    = 1'b1;
                w_waddr = r_clr;
                w_wdata = '0;
            end
            pcsm_pkg::ST_IDLE: begin
                // read top of stack and current save entry for the new instruction
                w_raddr = r_top;
                n_pn    = r_pc + PW'(1);
                n_flt   = 1'b0;
            end
            pcsm_pkg::ST_TOP: begin
                n_tv   = $signed(r_rdata);
                n_sv   = $signed(r_sdata);
                n_walk = $signed({{(DW-AW){1'b0}}, r_base});
                n_cnt  = r_in.level;
            end
            pcsm_pkg::ST_WALK_RD: begin
                w_raddr = r_walk[AW-1:0];
                if (r_walk[DW-1:AW] != '0) begin
                    // bad link: fault and continue from zero
                    n_flt  = 1'b1;
                    n_walk = '0;
                    n_cnt  = r_cnt - 4'd1;
                end
            end
            pcsm_pkg::ST_WALK_WT: begin
                n_walk = $signed(r_rdata);
                n_cnt  = r_cnt - 4'd1;
            end
            pcsm_pkg::ST_EXEC: begin
                case (r_in.op)
                    pcsm_pkg::OP_LIT, pcsm_pkg::OP_REA, pcsm_pkg::OP_LDR: begin
                        n_top   = r_top + AW'(1);
                        w_we    = 1'b1;
                        w_waddr = n_top;
                        w_wdata = (r_in.op == pcsm_pkg::OP_LIT) ? r_in.operand :
                                  (r_in.op == pcsm_pkg::OP_REA) ? r_in.read_value : r_ix;
                    end
                    pcsm_pkg::OP_OPR: begin
                        if (w_is_ret) begin
                            w_raddr = w_b2[AW-1:0];
                            n_rdok  = !w_b2[AW];
                            if (w_b2[AW]) n_flt = 1'b1;
                        end else if (r_in.operand == pcsm_pkg::OPR_NEG) begin
                            w_we    = 1'b1;
                            w_wdata = -r_tv;
                        end else if (w_is_bin) begin
                            // pop y, fetch x from the new top
                            n_top   = r_top - AW'(1);
                            w_raddr = n_top;
                        end
                    end
                    pcsm_pkg::OP_LOD, pcsm_pkg::OP_LDA: begin
                        w_raddr = w_ea[AW-1:0];
                        n_rdok  = w_ea_ok;
                        if (!w_ea_ok) n_flt = 1'b1;
                    end
                    pcsm_pkg::OP_STO, pcsm_pkg::OP_STA: begin
                        w_we    = w_ea_ok;
                        w_waddr = w_ea[AW-1:0];
                        if (!w_ea_ok) n_flt = 1'b1;
                        n_top = r_top - AW'(1);
                    end
                    pcsm_pkg::OP_CAL: begin
                        w_we    = !w_t2[AW];
                        w_waddr = w_t2[AW-1:0];
                        w_wdata = r_walk;
                        if (w_t2[AW]) n_flt = 1'b1;
                    end
                    pcsm_pkg::OP_INT:
                        n_top = r_top + r_in.operand[AW-1:0];
                    pcsm_pkg::OP_JMP:
                        n_pn = r_in.operand[PW-1:0];
                    pcsm_pkg::OP_JPC: begin
                        if (r_tv == '0) n_pn = r_in.operand[PW-1:0];
                        n_top = r_top - AW'(1);
                    end
                    pcsm_pkg::OP_STR: begin
                        if (r_in.operand == pcsm_pkg::STR_POPIX) begin
                            n_ix  = r_tv;
                            n_top = r_top - AW'(1);
                        end else if (r_in.operand == pcsm_pkg::STR_LINK) begin
                            w_we    = (r_base != '0);
                            w_waddr = r_base - AW'(1);
                            if (r_base == '0) n_flt = 1'b1;
                        end
                    end
                    pcsm_pkg::OP_GIV: begin
                        w_we    = w_ea_ok;
                        w_waddr = w_ea[AW-1:0];
                        w_wdata = r_ix;
                        if (!w_ea_ok) n_flt = 1'b1;
                    end
                    pcsm_pkg::OP_SAV: begin
                        n_sp     = r_sp + SW'(1);
                        w_swe    = 1'b1;
                        w_swaddr = n_sp;
                    end
                    pcsm_pkg::OP_GET: begin
                        n_ix = r_sv;
                        n_sp = r_sp - SW'(1);
                    end
                    pcsm_pkg::OP_WRI: begin
                        w_wv   = r_tv;
                        w_wvld = 1'b1;
                        n_top  = r_top - AW'(1);
                    end
                    default: ;
                endcase
            end
            pcsm_pkg::ST_RD2: begin
                if (r_in.op == pcsm_pkg::OP_OPR) begin
                    if (w_is_ret) begin
                        n_pn    = r_rdok ? r_rdata[PW-1:0] : '0;
                        w_raddr = w_b1[AW-1:0];
                        n_rdok  = !w_b1[AW];
                        if (w_b1[AW]) n_flt = 1'b1;
                    end else begin
                        case (r_in.operand)
                            pcsm_pkg::OPR_ADD: n_res = w_x + r_tv;
                            pcsm_pkg::OPR_SUB: n_res = w_x - r_tv;
                            pcsm_pkg::OPR_MUL: n_res = w_prod[DW-1:0];
                            pcsm_pkg::OPR_EQ:  n_res = DW'(w_x == r_tv);
                            pcsm_pkg::OPR_NE:  n_res = DW'(w_x != r_tv);
                            pcsm_pkg::OPR_LT:  n_res = DW'(w_x <  r_tv);
                            pcsm_pkg::OPR_GE:  n_res = DW'(w_x >= r_tv);
                            pcsm_pkg::OPR_GT:  n_res = DW'(w_x >  r_tv);
                            pcsm_pkg::OPR_LE:  n_res = DW'(w_x <= r_tv);
                            default: begin
                                // div or rem: zero divisor drops the write
                                if (r_tv == '0) n_flt = 1'b1;
                                else w_div_start = 1'b1;
                            end
                        endcase
                    end
                end else begin
                    n_top   = r_top + AW'(1);
                    w_we    = 1'b1;
                    w_waddr = n_top;
                    w_wdata = r_rdok ? r_rdata : '0;
                end
            end
            pcsm_pkg::ST_RD3: begin
                n_base = r_rdok ? r_rdata[AW-1:0] : '0;
                n_top  = (r_in.operand == pcsm_pkg::OPR_RET1) ? r_base - AW'(1)
                                                               : r_base - AW'(2);
            end
            pcsm_pkg::ST_CAL2: begin
                w_we    = !w_t3[AW];
                w_waddr = w_t3[AW-1:0];
                w_wdata = {{(DW-AW){1'b0}}, r_base};
                if (w_t3[AW]) n_flt = 1'b1;
            end
            pcsm_pkg::ST_CAL3: begin
                w_we    = !w_t4[AW];
                w_waddr = w_t4[AW-1:0];
                w_wdata = {{(DW-PW){1'b0}}, r_pn};
                if (w_t4[AW]) n_flt = 1'b1;
                n_base = w_t2[AW-1:0];
                n_pn   = r_in.operand[PW-1:0];
            end
            pcsm_pkg::ST_DIV: begin
                if (w_div_done)
                    n_res = (r_in.operand == pcsm_pkg::OPR_DIV) ? w_quot : w_rem;
            end
            pcsm_pkg::ST_WB: begin
                w_we    = 1'b1;
                w_wdata = r_res;
            end
            default: ;
        endcase

        if (w_fin) n_pc = n_pn;
        n_odata.next_pc     = n_pn;
        n_odata.write_value = w_wv;
        n_odata.write_valid = w_wvld;
        n_odata.halted      = (n_pn == '0);
        n_odata.fault       = n_flt;
    end

    // Memories: one write and one registered read per cycle each;
    // hold the stack read data while a finished result waits for the output
    always_ff @(posedge i_clk) begin
        if (w_we && !w_hold) r_stack[w_waddr] <= w_wdata;
        if (!w_hold) r_rdata <= r_stack[w_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (w_swe && !w_hold) r_save[w_swaddr] <= r_ix;
        r_sdata <= r_save[r_sp];
    end

    // Control and architectural state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= pcsm_pkg::ST_CLEAR;
            r_clr    <= '0;
            r_top    <= '0;
            r_base   <= AW'(2);
            r_pc     <= '0;
            r_ix     <= '0;
            r_sp     <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == pcsm_pkg::ST_CLEAR) r_clr <= r_clr + AW'(1);
            if (!w_hold) begin
                r_top  <= n_top;
                r_base <= n_base;
                r_pc   <= n_pc;
                r_ix   <= n_ix;
                r_sp   <= n_sp;
            end
            if (w_fin && w_fin_ok) r_ovalid <= 1'b1;
            else if (i_out_ready)  r_ovalid <= 1'b0;
        end
    end

    // Working registers: hold while a finished result waits for the output
    always_ff @(posedge i_clk) begin
        if (w_accept) r_in <= i_in_data;
        if (!w_hold) begin
            r_tv   <= n_tv;
            r_sv   <= n_sv;
            r_walk <= n_walk;
            r_cnt  <= n_cnt;
            r_pn   <= n_pn;
            r_flt  <= n_flt;
            r_rdok <= n_rdok;
            r_res  <= n_res;
        end
        if (w_fin && w_fin_ok) r_odata <= n_odata;
    end

endmodule
